// ===== sv/sbms_pkg.sv =====
// ----------------------------------------------------------------------------
// sbms_pkg
// Shared types, codes and constants of the SAD block-match search unit.
// ----------------------------------------------------------------------------
package sbms_pkg;

   localparam int BLOCK_SIDE       = 8;
   localparam int BLOCK_CELLS      = BLOCK_SIDE * BLOCK_SIDE;
   localparam int BLK_AW           = $clog2(BLOCK_CELLS);
   localparam int SEARCH_RANGE_DEF = 4;
   localparam int PIX_W            = 8;
   localparam int SAD_W            = 14;
   localparam int OFS_W            = 5;   // holds -16..15
   localparam int CSR_IDX_W        = 2;

   localparam logic [1:0] CMD_LOAD_REF = 2'd0;
   localparam logic [1:0] CMD_LOAD_WIN = 2'd1;
   localparam logic [1:0] CMD_RUN      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VAR_MIN     = 2'd1;

   localparam logic [SAD_W-1:0] MATCH_LIMIT_RST = 14'd16383;
   localparam logic [SAD_W-1:0] VAR_MIN_RST     = 14'd0;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [7:0]       addr;
      logic [PIX_W-1:0] pixel;
   } sbms_req_type;

   typedef struct packed {
      logic              match_found;
      logic              low_texture;
      logic signed [3:0] row_offset;
      logic signed [3:0] col_offset;
      logic [SAD_W-1:0]  best_sad;
   } sbms_rsp_type;

   // Datapath controls, aligned with the registered memory read data.
   typedef struct packed {
      logic                    clear;
      logic                    var_vld;
      logic                    sq_load;
      logic                    gate_load;
      logic                    sad_vld;
      logic                    sad_first;
      logic                    sad_last;
      logic signed [OFS_W-1:0] dr;
      logic signed [OFS_W-1:0] dc;
   } sbms_ctl_type;

   typedef struct packed {
      logic                    textured;
      logic [SAD_W-1:0]        best_sad;
      logic signed [OFS_W-1:0] best_row;
      logic signed [OFS_W-1:0] best_col;
   } sbms_res_type;

   typedef struct packed {
      logic                    last;
      logic signed [OFS_W-1:0] dr;
      logic signed [OFS_W-1:0] dc;
   } sbms_cand_type;

endpackage

// ===== sv/sbms_ram.sv =====
// ----------------------------------------------------------------------------
// sbms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sbms_spiral.sv =====
// ----------------------------------------------------------------------------
// sbms_spiral
// Walks candidate displacements in shell order: center, then per shell the
// top row, bottom row, left column and right column.
// ----------------------------------------------------------------------------
module sbms_spiral #(
   parameter int SEARCH_RANGE = sbms_pkg::SEARCH_RANGE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    step,
   output sbms_pkg::sbms_cand_type cand
);
   import sbms_pkg::*;

   localparam logic [2:0] PH_CENTER = 3'd0;
   localparam logic [2:0] PH_TOP    = 3'd1;
   localparam logic [2:0] PH_BOT    = 3'd2;
   localparam logic [2:0] PH_LEFT   = 3'd3;
   localparam logic [2:0] PH_RIGHT  = 3'd4;

   localparam logic signed [OFS_W-1:0] RANGE_S = OFS_W'(SEARCH_RANGE);
   localparam logic signed [OFS_W-1:0] ONE_S   = OFS_W'(1);

   logic [2:0]              phase_ff, phase_in;
   logic signed [OFS_W-1:0] shell_ff, shell_in;
   logic signed [OFS_W-1:0] dr_ff, dr_in;
   logic signed [OFS_W-1:0] dc_ff, dc_in;
   logic                    last_c;

   assign last_c = (phase_ff == PH_RIGHT) && (dr_ff == shell_ff - ONE_S) &&
                   (shell_ff == RANGE_S);

   always_comb begin
      phase_in = phase_ff;
      shell_in = shell_ff;
      dr_in    = dr_ff;
      dc_in    = dc_ff;
      if (start) begin
         phase_in = PH_CENTER;
         shell_in = '0;
         dr_in    = '0;
         dc_in    = '0;
      end else if (step) begin
         case (phase_ff)
            PH_CENTER: begin
               phase_in = PH_TOP;
               shell_in = ONE_S;
               dr_in    = -ONE_S;
               dc_in    = -ONE_S;
            end
            PH_TOP: begin
               if (dc_ff == shell_ff) begin
                  phase_in = PH_BOT;
                  dr_in    = shell_ff;
                  dc_in    = -shell_ff;
               end else begin
                  dc_in = dc_ff + ONE_S;
               end
            end
            PH_BOT: begin
               if (dc_ff == shell_ff) begin
                  phase_in = PH_LEFT;
                  dr_in    = ONE_S - shell_ff;
                  dc_in    = -shell_ff;
               end else begin
                  dc_in = dc_ff + ONE_S;
               end
            end
            PH_LEFT: begin
               if (dr_ff == shell_ff - ONE_S) begin
                  phase_in = PH_RIGHT;
                  dr_in    = ONE_S - shell_ff;
                  dc_in    = shell_ff;
               end else begin
                  dr_in = dr_ff + ONE_S;
               end
            end
            PH_RIGHT: begin
               if (dr_ff == shell_ff - ONE_S) begin
                  // next shell; holds on the last candidate
                  if (!last_c) begin
                     phase_in = PH_TOP;
                     shell_in = shell_ff + ONE_S;
                     dr_in    = -(shell_ff + ONE_S);
                     dc_in    = -(shell_ff + ONE_S);
                  end
               end else begin
                  dr_in = dr_ff + ONE_S;
               end
            end
            default: begin
               phase_in = PH_CENTER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CENTER;
         shell_ff <= '0;
         dr_ff    <= '0;
         dc_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         shell_ff <= shell_in;
         dr_ff    <= dr_in;
         dc_ff    <= dc_in;
      end
   end

   assign cand.last = last_c;
   assign cand.dr   = dr_ff;
   assign cand.dc   = dc_ff;

endmodule

// ===== sv/sbms_sad_acc.sv =====
// ----------------------------------------------------------------------------
// sbms_sad_acc
// Texture statistics, variance gate, SAD accumulation and best tracking.
// ----------------------------------------------------------------------------
module sbms_sad_acc (
   input  logic                          clock,
   input  sbms_pkg::sbms_ctl_type        ctl,
   input  logic [sbms_pkg::PIX_W-1:0]    ref_pix,
   input  logic [sbms_pkg::PIX_W-1:0]    win_pix,
   input  logic [sbms_pkg::SAD_W-1:0]    match_limit,
   input  logic [sbms_pkg::SAD_W-1:0]    var_min,
   output sbms_pkg::sbms_res_type        res
);
   import sbms_pkg::*;

   logic [13:0]             sum_ff;
   logic [21:0]             sumsq_ff;
   logic [27:0]             sq_ff;
   logic [15:0]             pix_sq;
   logic [28:0]             lhs, rhs;
   logic                    gate_pass;
   logic [PIX_W-1:0]        diff;
   logic [SAD_W-1:0]        acc_ff;
   logic [SAD_W-1:0]        sad_sum;
   logic                    textured_ff;
   logic [SAD_W-1:0]        best_ff;
   logic signed [OFS_W-1:0] brow_ff, bcol_ff;

   assign pix_sq = 16'(ref_pix) * 16'(ref_pix);

   // 64*sumsq < sum^2 + var_min*4096 means low texture
   assign lhs       = {1'b0, sumsq_ff, 6'b0};
   assign rhs       = 29'(sq_ff) + {3'b0, var_min, 12'b0};
   assign gate_pass = !(lhs < rhs);

   assign diff    = (ref_pix > win_pix) ? ref_pix - win_pix : win_pix - ref_pix;
   assign sad_sum = (ctl.sad_first ? '0 : acc_ff) + SAD_W'(diff);

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         sum_ff      <= '0;
         sumsq_ff    <= '0;
         textured_ff <= 1'b0;
         best_ff     <= match_limit;
         brow_ff     <= '0;
         bcol_ff     <= '0;
      end
      if (ctl.var_vld) begin
         sum_ff   <= sum_ff + 14'(ref_pix);
         sumsq_ff <= sumsq_ff + 22'(pix_sq);
      end
      if (ctl.sq_load) begin
         sq_ff <= 28'(sum_ff) * 28'(sum_ff);
      end
      if (ctl.gate_load) begin
         textured_ff <= gate_pass;
      end
      if (ctl.sad_vld) begin
         acc_ff <= sad_sum;
         if (ctl.sad_last && (sad_sum < best_ff)) begin
            best_ff <= sad_sum;
            brow_ff <= ctl.dr;
            bcol_ff <= ctl.dc;
         end
      end
   end

   assign res.textured = textured_ff;
   assign res.best_sad = best_ff;
   assign res.best_row = brow_ff;
   assign res.best_col = bcol_ff;

endmodule

// ===== sv/sad_block_match_search_unit.sv =====
// ----------------------------------------------------------------------------
// sad_block_match_search_unit
// Full-search SAD block matcher with a texture gate.
// ----------------------------------------------------------------------------
// Pixel load requests (reference block or search window) are accepted back
// to back. A run request first streams the 64 reference pixels to build sum
// and sum of squares, then passes the variance gate (ST_VDRAIN, ST_SQ,
// ST_GATE, ST_DECIDE); a textured block then scans (2*SEARCH_RANGE+1)^2
// candidates of 64 pixels each, then drains (ST_SDRAIN) and posts the
// response (ST_DONE), while a low-texture block goes straight to ST_DONE.
// The pace is set by the single read port of each pixel memory: one
// reference/window pixel pair per cycle. No request is taken during a
// run; a posted response may wait for rsp_ready while new loads are accepted.
// ----------------------------------------------------------------------------
module sad_block_match_search_unit #(
   parameter int SEARCH_RANGE = sbms_pkg::SEARCH_RANGE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sbms_pkg::sbms_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sbms_pkg::sbms_rsp_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sbms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbms_pkg::SAD_W-1:0]        csr_wdata
);
   import sbms_pkg::*;

   localparam int WIN_SIDE  = BLOCK_SIDE + 2 * SEARCH_RANGE;
   localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;
   localparam int WIN_AW    = $clog2(WIN_CELLS);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_VAR    = 4'd1;
   localparam logic [3:0] ST_VDRAIN = 4'd2;
   localparam logic [3:0] ST_SQ     = 4'd3;
   localparam logic [3:0] ST_GATE   = 4'd4;
   localparam logic [3:0] ST_DECIDE = 4'd5;
   localparam logic [3:0] ST_SEARCH = 4'd6;
   localparam logic [3:0] ST_SDRAIN = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [BLK_AW-1:0]  pix_ff, pix_in;
   sbms_ctl_type       ctl_ff, ctl_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sbms_rsp_type       rsp_ff, rsp_in;
   logic [SAD_W-1:0]   ceiling_ff, var_min_ff;

   logic               req_acc;
   logic               ref_wr, win_wr, rd_en;
   logic [WIN_AW-1:0]  win_wr_addr, win_rd_addr;
   logic [5:0]         win_row, win_col;
   logic [PIX_W-1:0]   ref_q, win_q;
   logic               spiral_start, spiral_step;
   sbms_cand_type      cand;
   sbms_res_type       res;
   logic               rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign ref_wr = req_acc && (req_data.cmd == CMD_LOAD_REF) &&
                   (32'(req_data.addr) < BLOCK_CELLS);
   assign win_wr = req_acc && (req_data.cmd == CMD_LOAD_WIN) &&
                   (32'(req_data.addr) < WIN_CELLS);
   assign win_wr_addr = WIN_AW'(req_data.addr);

   // window coordinates of the current pixel for the current candidate
   assign win_row = 6'(SEARCH_RANGE) + 6'(cand.dr) + 6'(pix_ff[5:3]);
   assign win_col = 6'(SEARCH_RANGE) + 6'(cand.dc) + 6'(pix_ff[2:0]);
   assign win_rd_addr = WIN_AW'(32'(win_row) * WIN_SIDE + 32'(win_col));

   assign rd_en = (state_ff == ST_VAR) || (state_ff == ST_SEARCH);

   sbms_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BLOCK_CELLS)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_wr),
      .wr_addr (req_data.addr[BLK_AW-1:0]),
      .wr_data (req_data.pixel),
      .rd_en   (rd_en),
      .rd_addr (pix_ff),
      .rd_data (ref_q)
   );

   sbms_ram #(
      .WIDTH (PIX_W),
      .DEPTH (WIN_CELLS)
   ) u_win_ram (
      .clock   (clock),
      .wr_en   (win_wr),
      .wr_addr (win_wr_addr),
      .wr_data (req_data.pixel),
      .rd_en   (rd_en),
      .rd_addr (win_rd_addr),
      .rd_data (win_q)
   );

   sbms_spiral #(
      .SEARCH_RANGE (SEARCH_RANGE)
   ) u_spiral (
      .clock (clock),
      .reset (reset),
      .start (spiral_start),
      .step  (spiral_step),
      .cand  (cand)
   );

   sbms_sad_acc u_sad_acc (
      .clock       (clock),
      .ctl         (ctl_ff),
      .ref_pix     (ref_q),
      .win_pix     (win_q),
      .match_limit (ceiling_ff),
      .var_min     (var_min_ff),
      .res         (res)
   );

   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      ctl_in       = '0;
      ctl_in.dr    = cand.dr;
      ctl_in.dc    = cand.dc;
      spiral_start = 1'b0;
      spiral_step  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_data.cmd == CMD_RUN)) begin
               ctl_in.clear = 1'b1;
               spiral_start = 1'b1;
               pix_in       = '0;
               state_in     = ST_VAR;
            end
         end
         ST_VAR: begin
            ctl_in.var_vld = 1'b1;
            pix_in         = pix_ff + BLK_AW'(1);
            if (&pix_ff) begin
               state_in = ST_VDRAIN;
            end
         end
         ST_VDRAIN: begin
            ctl_in.sq_load = 1'b1;
            state_in       = ST_SQ;
         end
         ST_SQ: begin
            ctl_in.gate_load = 1'b1;
            state_in         = ST_GATE;
         end
         ST_GATE: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = res.textured ? ST_SEARCH : ST_DONE;
         end
         ST_SEARCH: begin
            ctl_in.sad_vld   = 1'b1;
            ctl_in.sad_first = (pix_ff == '0);
            ctl_in.sad_last  = &pix_ff;
            pix_in           = pix_ff + BLK_AW'(1);
            if (&pix_ff) begin
               if (cand.last) begin
                  state_in = ST_SDRAIN;
               end else begin
                  spiral_step = 1'b1;
               end
            end
         end
         ST_SDRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.match_found = res.textured && (res.best_sad < ceiling_ff);
               rsp_in.low_texture = !res.textured;
               rsp_in.row_offset  = res.best_row[3:0];
               rsp_in.col_offset  = res.best_col[3:0];
               rsp_in.best_sad    = res.best_sad;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pix_ff       <= '0;
         ctl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ceiling_ff   <= MATCH_LIMIT_RST;
         var_min_ff   <= VAR_MIN_RST;
      end else begin
         state_ff     <= state_in;
         pix_ff       <= pix_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATCH_LIMIT: ceiling_ff <= csr_wdata;
               CSR_VAR_MIN:     var_min_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/sbms_checker.sv =====
// ----------------------------------------------------------------------------
// sbms_checker
// Port-level checks of the SAD block-match search unit, bound to the top.
// ----------------------------------------------------------------------------
module sbms_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input sbms_pkg::sbms_rsp_type rsp_data
);
   import sbms_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a new response only follows the busy tail of a run
   a_rsp_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a run");

   a_low_tex_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.low_texture |-> !rsp_data.match_found)
      else $error("low texture reported with a match");

   a_no_match_zero_ofs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.match_found |->
         rsp_data.row_offset == 4'sd0 && rsp_data.col_offset == 4'sd0)
      else $error("nonzero offset without a match");

endmodule

bind sad_block_match_search_unit sbms_checker u_sbms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== test/sad_block_match_search_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sad_block_match_search_unit_test
// Self-checking bench for the SAD block-match search unit. Pixel loads and
// search requests are queued and driven with random gaps and response stalls.
// Each accepted in-range pixel load updates a shadow copy of the block and window memories.
// A search request is predicted by a spiral-order full search with the
// variance gate. Results are compared field by field in arrival order. Phases
// of random load/search sequences run under varied ceiling and variance
// settings.
// ----------------------------------------------------------------------------
module sad_block_match_search_unit_test;
   import sbms_pkg::*;

   localparam int RANGE         = SEARCH_RANGE_DEF;
   localparam int WIN_SIDE      = BLOCK_SIDE + 2 * RANGE;
   localparam int WIN_CELLS     = WIN_SIDE * WIN_SIDE;
   localparam int WIN_AW        = $clog2(WIN_CELLS);
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 100;
   localparam int RANDOM_PHASES = 12;
   localparam int CALM_PHASES   = 3;

   localparam logic [1:0]           CMD_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   sbms_req_type         req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   sbms_rsp_type         rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SAD_W-1:0]     csr_wdata;

   // shadow memories as seen by the block, and the generator's own plan
   logic [PIX_W-1:0] blk_pix  [BLOCK_CELLS];
   logic [PIX_W-1:0] win_pix  [WIN_CELLS];
   logic [PIX_W-1:0] blk_plan [BLOCK_CELLS];
   logic [SAD_W-1:0] ceiling;
   logic [SAD_W-1:0] var_floor;

   sbms_req_type pending_reqs [$];
   sbms_rsp_type expected_rsps [$];
   sbms_rsp_type want_rsp;
   sbms_req_type next_req;
   logic         next_valid;

   bit req_accepted  = 1'b0;
   bit idle_on       = 1'b1;
   int req_gap       = 0;
   int rsp_hold      = 0;
   int phase_items   = 0;
   int mismatches    = 0;
   int requests_seen = 0;
   int results_seen  = 0;
   int matches_seen  = 0;
   int flat_seen     = 0;
   int reg_writes    = 0;

   sad_block_match_search_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Variance gate, then full search in shell order keeping the first strict minimum.
   function automatic sbms_rsp_type predict_search();
      longint unsigned total, squares;
      int best, best_r, best_c, s, k, r, c, a, b, acc;
      int ord_r [$];
      int ord_c [$];
      bit textured;
      sbms_rsp_type res;
      total   = 0;
      squares = 0;
      for (k = 0; k < BLOCK_CELLS; k++) begin
         total   += longint'(blk_pix[BLK_AW'(k)]);
         squares += longint'(blk_pix[BLK_AW'(k)]) * longint'(blk_pix[BLK_AW'(k)]);
      end
      textured = !(BLOCK_CELLS * squares < total * total + longint'(var_floor) * 4096);
      ord_r.push_back(0);
      ord_c.push_back(0);
      for (s = 1; s <= RANGE; s++) begin
         for (k = -s; k <= s; k++) begin
            ord_r.push_back(-s);
            ord_c.push_back(k);
         end
         for (k = -s; k <= s; k++) begin
            ord_r.push_back(s);
            ord_c.push_back(k);
         end
         for (k = 1 - s; k < s; k++) begin
            ord_r.push_back(k);
            ord_c.push_back(-s);
         end
         for (k = 1 - s; k < s; k++) begin
            ord_r.push_back(k);
            ord_c.push_back(s);
         end
      end
      best   = int'(ceiling);
      best_r = 0;
      best_c = 0;
      if (textured) begin
         for (k = 0; k < ord_r.size(); k++) begin
            acc = 0;
            for (r = 0; r < BLOCK_SIDE; r++) begin
               for (c = 0; c < BLOCK_SIDE; c++) begin
                  a = int'(blk_pix[BLK_AW'(r * BLOCK_SIDE + c)]);
                  b = int'(win_pix[WIN_AW'((RANGE + ord_r[k] + r) * WIN_SIDE +
                                           RANGE + ord_c[k] + c)]);
                  acc += (a > b) ? a - b : b - a;
               end
            end
            if (acc < best) begin
               best   = acc;
               best_r = ord_r[k];
               best_c = ord_c[k];
            end
         end
      end
      res.match_found = textured && (best < ceiling);
      res.low_texture = !textured;
      res.row_offset  = best_r[3:0];
      res.col_offset  = best_c[3:0];
      res.best_sad    = best[SAD_W-1:0];
      return res;
   endfunction

   task automatic check_field(input string label, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // monitor and predictor: sample at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         req_accepted = req_valid && req_ready;
         if (req_accepted) begin
            requests_seen++;
            case (req_data.cmd)
               CMD_LOAD_REF: begin
                  if (req_data.addr < BLOCK_CELLS)
                     blk_pix[req_data.addr[BLK_AW-1:0]] = req_data.pixel;
               end
               CMD_LOAD_WIN: begin
                  if (req_data.addr < WIN_CELLS) win_pix[req_data.addr] = req_data.pixel;
               end
               CMD_RUN: expected_rsps.push_back(predict_search());
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: result with none expected, got %p", $time, rsp_data);
               mismatches++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               check_field("match_found", want_rsp.match_found, rsp_data.match_found);
               check_field("low_texture", want_rsp.low_texture, rsp_data.low_texture);
               check_field("row_offset", want_rsp.row_offset, rsp_data.row_offset);
               check_field("col_offset", want_rsp.col_offset, rsp_data.col_offset);
               check_field("best_sad", want_rsp.best_sad, rsp_data.best_sad);
               results_seen++;
               if (want_rsp.match_found) matches_seen++;
               if (want_rsp.low_texture) flat_seen++;
            end
         end
      end
   end

   // driver: inputs move at the falling edge
   always @(negedge clock) begin
      next_valid = req_valid && !req_accepted;
      next_req   = req_data;
      if (!reset && !next_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(0, 9);
         end else if (pending_reqs.size() > 0) begin
            next_req   = pending_reqs.pop_front();
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
      req_data  <= next_req;
      if (rsp_hold > 0) begin
         rsp_hold--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_hold = $urandom_range(1, 10);
      end
      rsp_ready <= (rsp_hold == 0);
   end

   task automatic push_req(input logic [1:0] cmd, input logic [7:0] addr,
                           input logic [PIX_W-1:0] pixel);
      sbms_req_type item;
      item.cmd   = cmd;
      item.addr  = addr;
      item.pixel = pixel;
      pending_reqs.push_back(item);
      if (cmd == CMD_LOAD_REF && addr < BLOCK_CELLS) blk_plan[addr[BLK_AW-1:0]] = pixel;
      if (cmd == CMD_RUN || cmd == CMD_LOAD_WIN || (cmd == CMD_LOAD_REF && addr < BLOCK_CELLS))
         phase_items++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SAD_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MATCH_LIMIT: ceiling = val;
         CSR_VAR_MIN:     var_floor = val;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one load sequence closed by a search request
   task automatic add_sequence();
      int kind, n, k, row0, col0;
      bit noisy;
      logic [PIX_W-1:0] v;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         // plant a copy of the block somewhere in the window
         row0  = $urandom_range(0, 2 * RANGE);
         col0  = $urandom_range(0, 2 * RANGE);
         noisy = $urandom_range(0, 1);
         for (k = 0; k < BLOCK_CELLS; k++) begin
            v = blk_plan[BLK_AW'(k)];
            if (noisy && $urandom_range(0, 3) == 0) v = v ^ PIX_W'($urandom_range(1, 3));
            push_req(CMD_LOAD_WIN,
                     8'((row0 + k / BLOCK_SIDE) * WIN_SIDE + col0 + k % BLOCK_SIDE), v);
         end
      end else if (kind == 1) begin
         // flat or nearly flat block: variance gate boundary and tied candidates
         v     = PIX_W'($urandom_range(0, 254));
         noisy = $urandom_range(0, 1);
         for (k = 0; k < BLOCK_CELLS; k++)
            push_req(CMD_LOAD_REF, 8'(k),
                     v + PIX_W'((noisy && $urandom_range(0, 7) == 0) ? 1 : 0));
      end else begin
         n = $urandom_range(2, 24);
         for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 15))
               0:             push_req(CMD_LOAD_REF, 8'($urandom_range(BLOCK_CELLS, 255)),
                                       PIX_W'($urandom));
               1:             push_req(CMD_UNUSED, 8'($urandom), PIX_W'($urandom));
               2, 3, 4, 5, 6: push_req(CMD_LOAD_REF, 8'($urandom_range(0, BLOCK_CELLS - 1)),
                                       PIX_W'($urandom));
               default:       push_req(CMD_LOAD_WIN, 8'($urandom_range(0, WIN_CELLS - 1)),
                                       PIX_W'($urandom));
            endcase
         end
      end
      push_req(CMD_RUN, 8'($urandom), PIX_W'($urandom));
   endtask

   initial begin
      int k, phase;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      ceiling   = MATCH_LIMIT_RST;
      var_floor = VAR_MIN_RST;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // both memories fully written before the first search
      for (k = 0; k < BLOCK_CELLS; k++) push_req(CMD_LOAD_REF, 8'(k), PIX_W'($urandom));
      for (k = 0; k < WIN_CELLS; k++) push_req(CMD_LOAD_WIN, 8'(k), PIX_W'($urandom));
      push_req(CMD_RUN, 8'h00, 8'h00);
      push_req(CMD_UNUSED, 8'hFF, 8'hFF);
      push_req(CMD_LOAD_REF, 8'(BLOCK_CELLS), 8'h5A);
      push_req(CMD_LOAD_REF, 8'hFF, 8'h00);
      push_req(CMD_LOAD_REF, 8'd0, 8'h00);
      push_req(CMD_LOAD_REF, 8'(BLOCK_CELLS - 1), 8'hFF);
      push_req(CMD_LOAD_WIN, 8'd0, 8'hFF);
      push_req(CMD_LOAD_WIN, 8'(WIN_CELLS - 1), 8'h00);
      push_req(CMD_RUN, 8'hFF, 8'hFF);
      push_req(CMD_UNUSED, 8'h00, 8'h00);
      push_req(CMD_RUN, 8'hA5, 8'h5A);
      wait_idle();

      // zero ceiling: nothing can match
      write_reg(CSR_MATCH_LIMIT, '0);
      push_req(CMD_RUN, 8'h00, 8'h00);
      push_req(CMD_LOAD_WIN, 8'h80, 8'h7F);
      push_req(CMD_RUN, 8'h00, 8'h00);
      wait_idle();

      // top variance floor: every block is low texture
      write_reg(CSR_MATCH_LIMIT, '1);
      write_reg(CSR_VAR_MIN, '1);
      write_reg(CSR_UNMAPPED, 14'h2AAA);
      push_req(CMD_RUN, 8'h00, 8'h00);
      push_req(CMD_LOAD_REF, 8'h20, 8'h80);
      push_req(CMD_RUN, 8'h00, 8'h00);
      wait_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase < RANDOM_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_MATCH_LIMIT, '1);
            1:       write_reg(CSR_MATCH_LIMIT, SAD_W'($urandom_range(0, 16383)));
            default: write_reg(CSR_MATCH_LIMIT, SAD_W'($urandom_range(0, 1500)));
         endcase
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_VAR_MIN, '0);
            1:       write_reg(CSR_VAR_MIN, SAD_W'($urandom_range(0, 16383)));
            default: write_reg(CSR_VAR_MIN, SAD_W'($urandom_range(0, 6000)));
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) add_sequence();
         wait_idle();
      end

      $display("covered %0d requests, %0d search results (%0d matched, %0d low texture)",
               requests_seen, results_seen, matches_seen, flat_seen);
      $display("across %0d register writes and %0d setting phases", reg_writes, RANDOM_PHASES + 3);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #24_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, expected_rsps.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/sbms_pkg.sv
sv/sbms_ram.sv
sv/sbms_spiral.sv
sv/sbms_sad_acc.sv
sv/sad_block_match_search_unit.sv
sv/sbms_checker.sv
test/sad_block_match_search_unit_test.sv
